// ===== sv/cpal_pkg.sv =====
// Package: widths, codes and item types of the closed-path arc-length lookup.
`default_nettype none
package cpal_pkg;
  localparam int MAX_POINTS = 1024;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int ADDR_W = $clog2(MAX_POINTS + 1);
  localparam int DEPTH  = MAX_POINTS + 1;
  localparam int CRD_W  = 24;
  localparam int DIF_W  = CRD_W + 1;
  localparam int SQ_W   = 2 * DIF_W;
  localparam int ROOT_W = DIF_W;
  localparam int LEN_W  = 32;
  localparam int SEG_W  = 10;
  localparam int FRAC_W = 17;
  localparam int PC_W   = 11;
  localparam int CS_W   = LEN_W + 2;
  localparam int STEP_W = 6;

  localparam logic ACT_APPEND = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_NOPATH = 2'd2;

  typedef struct packed {
    logic                     action;
    logic signed [CRD_W-1:0]  point_x;
    logic signed [CRD_W-1:0]  point_y;
    logic signed [CRD_W-1:0]  point_z;
    logic                     last_point;
    logic signed [LEN_W-1:0]  query_distance;
  } cmd_t;

  typedef struct packed {
    logic [SEG_W-1:0]  segment_index;
    logic [FRAC_W-1:0] fraction;
    logic [LEN_W-1:0]  total_length;
    logic [PC_W-1:0]   point_count;
    logic [1:0]        status;
  } res_t;
endpackage
`default_nettype wire

// ===== sv/cpal_if.sv =====
// Valid/ready channel interfaces for command and result items.
`default_nettype none
interface cpal_cmd_if;
  logic          valid;
  logic          ready;
  cpal_pkg::cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cpal_res_if;
  logic          valid;
  logic          ready;
  cpal_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/cpal_ram.sv =====
// Cumulative length table: one write port, one registered read port.
`default_nettype none
module cpal_ram (
  input  wire                          clk,
  input  wire                          wr_en,
  input  wire [cpal_pkg::ADDR_W-1:0]   wr_addr,
  input  wire [cpal_pkg::LEN_W-1:0]    wr_data,
  input  wire [cpal_pkg::ADDR_W-1:0]   rd_addr,
  output logic [cpal_pkg::LEN_W-1:0]   rd_data
);
  import cpal_pkg::*;

  logic [LEN_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

// ===== sv/cpal_csub.sv =====
// Shared compare-subtract step for square root, modulo and fraction division.
`default_nettype none
module cpal_csub (
  input  wire [cpal_pkg::CS_W-1:0]  a,
  input  wire [cpal_pkg::CS_W-1:0]  b,
  output logic                      ge,
  output logic [cpal_pkg::CS_W-1:0] diff
);
  import cpal_pkg::*;

  logic [CS_W:0] d;

  always_comb begin
    d    = {1'b0, a} - {1'b0, b};
    ge   = ~d[CS_W];
    diff = d[CS_W-1:0];
  end
endmodule
`default_nettype wire

// ===== sv/closed_path_arc_length_lookup_top.sv =====
// Top level: sequencer, datapath registers and result register of the arc-length lookup.
// An append computes the distance from the previous point: three squares through one
// 25x25 multiplier and a 25-step square root on a shared compare-subtract unit. A first
// point that does not close the loop is only stored. A closing point also runs that sequence
// from the last stored point to the first, and a dropped point that does not close the loop
// goes straight to the result. A query runs a 32-step modulo, a binary search of up to 11
// probes (the table has one registered read port), two table reads and a 17-step division;
// the modulo and the division use that same compare-subtract unit. One item is worked at a
// time; a new item is taken as soon as the previous result sits in the output register, and
// a result that waits there holds the block. The table needs no clearing.
`default_nettype none
module closed_path_arc_length_lookup_top (
  input wire clk,
  input wire rst,
  cpal_cmd_if.sink   cmd,
  cpal_res_if.source res
);
  import cpal_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE     = 16'h0001,
    S_APPEND   = 16'h0002,
    S_SQ       = 16'h0004,
    S_SQSUM    = 16'h0008,
    S_SQRT     = 16'h0010,
    S_ACC      = 16'h0020,
    S_QUERY    = 16'h0040,
    S_MOD      = 16'h0080,
    S_WRAP     = 16'h0100,
    S_BS_ISSUE = 16'h0200,
    S_BS_CMP   = 16'h0400,
    S_RD_START = 16'h0800,
    S_RD_END   = 16'h1000,
    S_RD_LAST  = 16'h2000,
    S_FRAC     = 16'h4000,
    S_DONE     = 16'h8000
  } state_t;

  state_t state;
  cmd_t   item;

  logic signed [CRD_W-1:0] first_x, first_y, first_z;
  logic signed [CRD_W-1:0] prev_x, prev_y, prev_z;
  logic [CNT_W-1:0]  loaded;
  logic              closed;
  logic [LEN_W-1:0]  tail;
  logic [LEN_W-1:0]  total;
  logic [1:0]        status;
  logic              phase_close;

  logic [STEP_W-1:0]       cnt;
  logic signed [SQ_W-1:0]  prod;
  logic [SQ_W-1:0]         acc;
  logic [SQ_W-1:0]         v;
  logic [ROOT_W-1:0]       root;
  logic [CS_W-1:0]         rem;
  logic [LEN_W-1:0]        dvd;
  logic                    neg;
  logic [LEN_W-1:0]        r;
  logic [CNT_W-1:0]        segs, lo, hi, mid;
  logic [LEN_W-1:0]        start, len;
  logic [FRAC_W-1:0]       quot;

  logic                    res_valid;
  res_t                    res_data;

  // shared unit operands
  logic [CS_W-1:0] cs_a, cs_b, cs_diff;
  logic            cs_ge;

  cpal_csub u_csub (.a(cs_a), .b(cs_b), .ge(cs_ge), .diff(cs_diff));

  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr, rd_addr;
  logic [LEN_W-1:0]   wr_data, rd_data;

  cpal_ram u_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  // distance operands and one square per cycle
  logic signed [CRD_W-1:0] ca, cb;
  logic signed [DIF_W-1:0] dif;
  logic [LEN_W:0]          sum_raw;
  logic [LEN_W-1:0]        sum_sat;
  logic [CNT_W:0]          mid_sum;

  always_comb begin
    case (cnt[1:0])
      2'd0:    begin ca = prev_x; cb = phase_close ? first_x : item.point_x; end
      2'd1:    begin ca = prev_y; cb = phase_close ? first_y : item.point_y; end
      default: begin ca = prev_z; cb = phase_close ? first_z : item.point_z; end
    endcase
    dif = DIF_W'(ca) - DIF_W'(cb);
    sum_raw = {1'b0, tail} + (LEN_W + 1)'(root);
    sum_sat = sum_raw[LEN_W] ? {LEN_W{1'b1}} : sum_raw[LEN_W-1:0];
    mid_sum = {1'b0, lo} + {1'b0, hi};
    mid     = mid_sum[CNT_W:1];
  end

  always_comb begin
    cs_a = '0;
    cs_b = '0;
    case (state)
      S_SQRT: begin
        cs_a = {rem[CS_W-3:0], v[SQ_W-1 -: 2]};
        cs_b = CS_W'({root, 2'b01});
      end
      S_MOD: begin
        cs_a = {rem[CS_W-2:0], dvd[LEN_W-1]};
        cs_b = CS_W'(total);
      end
      S_FRAC: begin
        cs_a = (cnt == '0) ? rem : {rem[CS_W-2:0], 1'b0};
        cs_b = CS_W'(len);
      end
      default: begin
        cs_a = '0;
        cs_b = '0;
      end
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    rd_addr = '0;
    case (state)
      S_APPEND: begin
        wr_en = (loaded == '0);
      end
      S_ACC: begin
        wr_en   = 1'b1;
        wr_addr = ADDR_W'(loaded);
        wr_data = sum_sat;
      end
      S_BS_ISSUE: rd_addr = ADDR_W'(mid + CNT_W'(1));
      S_RD_START: rd_addr = ADDR_W'(lo);
      S_RD_END:   rd_addr = ADDR_W'(lo + CNT_W'(1));
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  assign cmd.ready  = (state == S_IDLE);
  assign res.valid  = res_valid;
  assign res.data   = res_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      loaded    <= '0;
      closed    <= 1'b1;
      first_x   <= '0; first_y <= '0; first_z <= '0;
      prev_x    <= '0; prev_y  <= '0; prev_z  <= '0;
      tail      <= '0;
      total     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!res_valid || res.ready)) begin
        res_valid <= 1'b1;
      end else if (res_valid && res.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            item   <= cmd.data;
            status <= ST_OK;
            lo     <= '0;
            quot   <= '0;
            len    <= '0;
            if (cmd.data.action == ACT_APPEND) begin
              if (closed) begin
                loaded <= '0;
                closed <= 1'b0;
              end
              state <= S_APPEND;
            end else begin
              state <= S_QUERY;
            end
          end
        end
        S_APPEND: begin
          cnt  <= '0;
          acc  <= '0;
          prod <= '0;
          if (loaded >= CNT_W'(MAX_POINTS)) begin
            status      <= ST_FULL;
            phase_close <= 1'b1;
            if (item.last_point) begin
              state <= S_SQ;
            end else begin
              total <= tail;
              state <= S_DONE;
            end
          end else if (loaded == '0) begin
            first_x <= item.point_x; first_y <= item.point_y; first_z <= item.point_z;
            prev_x  <= item.point_x; prev_y  <= item.point_y; prev_z  <= item.point_z;
            tail        <= '0;
            loaded      <= CNT_W'(1);
            phase_close <= 1'b1;
            if (item.last_point) begin
              state <= S_SQ;
            end else begin
              total <= '0;
              state <= S_DONE;
            end
          end else begin
            phase_close <= 1'b0;
            state       <= S_SQ;
          end
        end
        S_SQ: begin
          prod <= dif * dif;
          acc  <= acc + prod;
          cnt  <= cnt + STEP_W'(1);
          if (cnt == STEP_W'(2)) begin
            state <= S_SQSUM;
          end
        end
        S_SQSUM: begin
          v     <= acc + prod;
          rem   <= '0;
          root  <= '0;
          cnt   <= '0;
          state <= S_SQRT;
        end
        S_SQRT: begin
          rem  <= cs_ge ? cs_diff : cs_a;
          root <= {root[ROOT_W-2:0], cs_ge};
          v    <= {v[SQ_W-3:0], 2'b00};
          cnt  <= cnt + STEP_W'(1);
          if (cnt == STEP_W'(ROOT_W - 1)) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          if (phase_close) begin
            total  <= sum_sat;
            closed <= 1'b1;
            state  <= S_DONE;
          end else begin
            tail   <= sum_sat;
            prev_x <= item.point_x; prev_y <= item.point_y; prev_z <= item.point_z;
            loaded <= loaded + CNT_W'(1);
            if (item.last_point) begin
              phase_close <= 1'b1;
              cnt         <= '0;
              acc         <= '0;
              prod        <= '0;
              state       <= S_SQ;
            end else begin
              total <= sum_sat;
              state <= S_DONE;
            end
          end
        end
        S_QUERY: begin
          segs <= closed ? loaded : loaded - CNT_W'(1);
          hi   <= closed ? loaded : loaded - CNT_W'(1);
          neg  <= item.query_distance[LEN_W-1];
          dvd  <= item.query_distance[LEN_W-1] ? (~item.query_distance + LEN_W'(1))
                                               : item.query_distance;
          rem  <= '0;
          cnt  <= '0;
          if (loaded == '0 || total == '0) begin
            status <= ST_NOPATH;
            state  <= S_DONE;
          end else begin
            state <= S_MOD;
          end
        end
        S_MOD: begin
          rem <= cs_ge ? cs_diff : cs_a;
          dvd <= {dvd[LEN_W-2:0], 1'b0};
          cnt <= cnt + STEP_W'(1);
          if (cnt == STEP_W'(LEN_W - 1)) begin
            state <= S_WRAP;
          end
        end
        S_WRAP: begin
          r     <= (neg && rem != '0) ? (total - rem[LEN_W-1:0]) : rem[LEN_W-1:0];
          state <= S_BS_ISSUE;
        end
        S_BS_ISSUE: begin
          if (lo < hi) begin
            state <= S_BS_CMP;
          end else begin
            if (lo >= segs) begin
              lo <= segs - CNT_W'(1);
            end
            state <= S_RD_START;
          end
        end
        S_BS_CMP: begin
          // lo and hi are held while the probe read is in flight, so mid is still the probe
          if (rd_data < r) begin
            lo <= mid + CNT_W'(1);
          end else begin
            hi <= mid;
          end
          state <= S_BS_ISSUE;
        end
        S_RD_START: state <= S_RD_END;
        S_RD_END: begin
          start <= rd_data;
          state <= S_RD_LAST;
        end
        S_RD_LAST: begin
          len   <= rd_data - start;
          rem   <= CS_W'(r - start);
          cnt   <= '0;
          quot  <= '0;
          state <= S_FRAC;
        end
        S_FRAC: begin
          rem  <= cs_ge ? cs_diff : cs_a;
          quot <= {quot[FRAC_W-2:0], cs_ge};
          cnt  <= cnt + STEP_W'(1);
          if (cnt == STEP_W'(FRAC_W - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!res_valid || res.ready) begin
            res_data.segment_index   <= lo[SEG_W-1:0];
            res_data.fraction        <= (len == '0) ? '0 : quot;
            res_data.total_length    <= total;
            res_data.point_count     <= PC_W'(loaded);
            res_data.status          <= status;
            state                    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
